// ===== rtl/ffrc_pkg.sv =====
// shared widths, constants, request types and grading functions of the fuzzy controller
// no dependencies; taken in by every other file of the block
package ffrc_pkg;

  localparam int NUM_RULES = 4;
  localparam int DATA_W    = 12;                 // q4.8 inputs and output
  localparam int CENTRE_W  = 4;                  // rule midpoints, integer units
  localparam int STR_W     = 10;                 // membership / strength, 512 = 1.0
  localparam int DEN_W     = 12;                 // sum of four strengths
  localparam int NUM_W     = 16;                 // signed sum of strength * midpoint
  localparam int MAG_W     = NUM_W - 1;          // magnitude of that sum
  localparam int QUO_W     = DATA_W;             // quotient magnitude bits
  localparam int ROUND_SH  = 9;                  // q-one (8 bits) plus the doubling for rounding
  localparam int DVD_W     = MAG_W + ROUND_SH;   // rounded dividend
  localparam int DIV_W     = DEN_W + 1;          // doubled denominator
  localparam int ADDR_W    = 4;
  localparam int PDATA_W   = 32;

  // set centres and half-width in raw q4.8
  localparam logic signed [DATA_W:0] SET_POS  = 13'sd512;
  localparam logic signed [DATA_W:0] SET_ZERO = 13'sd0;
  localparam logic signed [DATA_W:0] SET_NEG  = -13'sd512;
  localparam logic [DATA_W:0]        HALF_W   = 13'd512;

  // register indexes
  localparam logic [1:0] REG_RULE1 = 2'd0;
  localparam logic [1:0] REG_RULE2 = 2'd1;
  localparam logic [1:0] REG_RULE3 = 2'd2;
  localparam logic [1:0] REG_RULE4 = 2'd3;

  // midpoint reset values
  localparam logic [CENTRE_W-1:0] RULE1_RST = 4'b1110;
  localparam logic [CENTRE_W-1:0] RULE2_RST = 4'b0000;
  localparam logic [CENTRE_W-1:0] RULE3_RST = 4'b0010;
  localparam logic [CENTRE_W-1:0] RULE4_RST = 4'b0100;

  typedef logic [CENTRE_W-1:0] centre_t;
  typedef centre_t [NUM_RULES-1:0] centre_set_t;
  typedef logic [STR_W-1:0] strength_t;

  // one request queued between front and back
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
  } queue_entry_t;

  // triangular membership of half-width two around centre c
  function automatic strength_t grade(input logic [DATA_W-1:0] x,
                                      input logic signed [DATA_W:0] c);
    logic signed [DATA_W:0] d;
    logic [DATA_W:0]        mag;
    d   = $signed({x[DATA_W-1], x}) - c;
    mag = d[DATA_W] ? 13'(-d) : 13'(d);
    if (mag < HALF_W) begin
      grade = STR_W'(HALF_W - mag);
    end else begin
      grade = '0;
    end
  endfunction

  function automatic strength_t min_str(input strength_t a, input strength_t b);
    min_str = (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/ffrc_in_if.sv =====
// input channel of the fuzzy controller: error and error change
// depends on ffrc_pkg
interface ffrc_in_if;
  import ffrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] error_value;
  logic [DATA_W-1:0] error_change;

  modport source (output valid, output error_value, output error_change, input ready);
  modport sink   (input valid, input error_value, input error_change, output ready);
endinterface

// ===== rtl/ffrc_out_if.sv =====
// result channel of the fuzzy controller: control value and no-rule flag
// depends on ffrc_pkg
interface ffrc_out_if;
  import ffrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] control_value;
  logic              no_rule_fired;

  modport source (output valid, output control_value, output no_rule_fired, input ready);
  modport sink   (input valid, input control_value, input no_rule_fired, output ready);
endinterface

// ===== rtl/ffrc_cfg_regs.sv =====
// apb register file holding the four rule midpoints
// depends on ffrc_pkg
module ffrc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ffrc_pkg::PDATA_W-1:0] pwdata,
  output logic [ffrc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output ffrc_pkg::centre_set_t        centres
);
  import ffrc_pkg::*;

  centre_t    rule1_r, rule2_r, rule3_r, rule4_r;
  logic [1:0] reg_idx;
  logic       wr_en;
  centre_t    rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule1_r <= RULE1_RST;
      rule2_r <= RULE2_RST;
      rule3_r <= RULE3_RST;
      rule4_r <= RULE4_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RULE1: rule1_r <= pwdata[CENTRE_W-1:0];
        REG_RULE2: rule2_r <= pwdata[CENTRE_W-1:0];
        REG_RULE3: rule3_r <= pwdata[CENTRE_W-1:0];
        REG_RULE4: rule4_r <= pwdata[CENTRE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, sign extended
  always_comb begin
    case (reg_idx)
      REG_RULE1: rd_val = rule1_r;
      REG_RULE2: rd_val = rule2_r;
      REG_RULE3: rd_val = rule3_r;
      REG_RULE4: rd_val = rule4_r;
      default:   rd_val = '0;
    endcase
  end

  assign prdata  = {{(PDATA_W-CENTRE_W){rd_val[CENTRE_W-1]}}, rd_val};
  assign centres = {rule4_r, rule3_r, rule2_r, rule1_r};

endmodule

// ===== rtl/ffrc_front.sv =====
// front end: accepts requests, grades them into rule strengths and forms
// the weighted sum and the denominator; depends on ffrc_pkg and ffrc_in_if
module ffrc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  ffrc_in_if.sink                in_ch,
  input  ffrc_pkg::centre_set_t  centres,
  input  logic                   q_full,
  output logic                   q_push,
  output ffrc_pkg::queue_entry_t q_entry
);
  import ffrc_pkg::*;

  logic      f_vld_r;
  strength_t str_r [NUM_RULES];
  strength_t str_nxt [NUM_RULES];
  strength_t g_e_zero, g_e_neg, g_ec_pos, g_ec_zero, g_ec_neg;

  logic signed [NUM_W-1:0] prod [NUM_RULES];
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;

  assign in_ch.ready = !f_vld_r || !q_full;

  // memberships and rule strengths
  always_comb begin
    g_e_zero   = grade(in_ch.error_value, SET_ZERO);
    g_e_neg    = grade(in_ch.error_value, SET_NEG);
    g_ec_pos   = grade(in_ch.error_change, SET_POS);
    g_ec_zero  = grade(in_ch.error_change, SET_ZERO);
    g_ec_neg   = grade(in_ch.error_change, SET_NEG);
    str_nxt[0] = min_str(g_e_zero, g_ec_pos);
    str_nxt[1] = min_str(g_e_zero, g_ec_zero);
    str_nxt[2] = min_str(g_e_neg, g_ec_neg);
    str_nxt[3] = min_str(g_e_neg, g_ec_zero);
  end

  // strength register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      f_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      for (int i = 0; i < NUM_RULES; i++) begin
        str_r[i] <= str_nxt[i];
      end
    end
  end

  // weighted sum of midpoints and sum of strengths
  always_comb begin
    num = '0;
    den = '0;
    for (int i = 0; i < NUM_RULES; i++) begin
      prod[i] = $signed({{(NUM_W-STR_W){1'b0}}, str_r[i]}) *
                $signed({{(NUM_W-CENTRE_W){centres[i][CENTRE_W-1]}}, centres[i]});
      num     = num + prod[i];
      den     = den + DEN_W'(str_r[i]);
    end
  end

  assign q_push      = f_vld_r && !q_full;
  assign q_entry.neg = num[NUM_W-1];
  assign q_entry.mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
  assign q_entry.den = den;

endmodule

// ===== rtl/ffrc_queue.sv =====
// short fifo of requests between front and back
// depends on ffrc_pkg
module ffrc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ffrc_pkg::queue_entry_t push_entry,
  input  logic                   pop,
  output ffrc_pkg::queue_entry_t pop_entry,
  output logic                   full,
  output logic                   empty
);
  import ffrc_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  queue_entry_t     mem_r [DEPTH];
  logic [IDX_W-1:0] wr_idx_r, rd_idx_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign pop_entry = mem_r[rd_idx_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_idx_r <= (wr_idx_r == LAST) ? '0 : wr_idx_r + 1'b1;
      end
      if (pop) begin
        rd_idx_r <= (rd_idx_r == LAST) ? '0 : rd_idx_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_idx_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/ffrc_back.sv =====
// back end: pipelined restoring divider, one quotient bit a stage, then
// sign and no-rule handling into the output register; depends on ffrc_pkg, ffrc_out_if
module ffrc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ffrc_pkg::queue_entry_t q_entry,
  input  logic                   q_empty,
  output logic                   q_pop,
  ffrc_out_if.source             out_ch
);
  import ffrc_pkg::*;

  localparam int STEPS = QUO_W;

  logic             bk_adv;
  logic             vld_r  [STEPS+1];
  logic             neg_r  [STEPS+1];
  logic             none_r [STEPS+1];
  logic [DIV_W-1:0] div_r  [STEPS+1];
  logic [DIV_W-1:0] rem_r  [STEPS+1];
  logic [QUO_W-1:0] work_r [STEPS+1];
  logic [DVD_W-1:0] dividend;

  logic              out_valid_r;
  logic [DATA_W-1:0] ctrl_r, ctrl_nxt;
  logic              flag_r;

  // whole pipe moves unless a finished result is held
  assign bk_adv = !out_valid_r || out_ch.ready;
  assign q_pop  = bk_adv && !q_empty;

  // rounded dividend: 2 * |num| * 256 + den, divided by 2 * den
  assign dividend = {q_entry.mag, {ROUND_SH{1'b0}}} + DVD_W'(q_entry.den);

  // stage zero, loaded from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (bk_adv) begin
      vld_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (bk_adv) begin
      neg_r[0]  <= q_entry.neg;
      none_r[0] <= (q_entry.den == '0);
      div_r[0]  <= {q_entry.den, 1'b0};
      rem_r[0]  <= {1'b0, dividend[DVD_W-1:QUO_W]};
      work_r[0] <= dividend[QUO_W-1:0];
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [DIV_W:0]   cat;
    logic [DIV_W+1:0] diff;
    logic             take;

    always_comb begin
      cat  = {rem_r[k-1], work_r[k-1][QUO_W-1]};
      diff = {1'b0, cat} - {2'b0, div_r[k-1]};
      take = ~diff[DIV_W+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (bk_adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (bk_adv) begin
        neg_r[k]  <= neg_r[k-1];
        none_r[k] <= none_r[k-1];
        div_r[k]  <= div_r[k-1];
        rem_r[k]  <= take ? diff[DIV_W-1:0] : cat[DIV_W-1:0];
        work_r[k] <= {work_r[k-1][QUO_W-2:0], take};
      end
    end
  end

  // sign and no-rule case
  always_comb begin
    if (none_r[STEPS]) begin
      ctrl_nxt = '0;
    end else if (neg_r[STEPS]) begin
      ctrl_nxt = DATA_W'(-work_r[STEPS]);
    end else begin
      ctrl_nxt = DATA_W'(work_r[STEPS]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (bk_adv) begin
      out_valid_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (bk_adv) begin
      ctrl_r <= ctrl_nxt;
      flag_r <= none_r[STEPS];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.control_value = ctrl_r;
  assign out_ch.no_rule_fired = flag_r;

endmodule

// ===== rtl/fuzzy_four_rule_controller.sv =====
// four-rule fuzzy controller, weighted-average output in q4.8
// grading is registered at the accepting edge itself, then the request passes the queue,
// stage zero that loads the divider, twelve divider stages (one quotient bit each) and
// the output register; throughput: one request per cycle unless a finished result is
// held at the output; the divider pipeline sets this figure
// reset: synchronous, active low; midpoints return to -2, 0, 2, 4, queue empties
module fuzzy_four_rule_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ffrc_in_if.sink                      in_ch,
  ffrc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ffrc_pkg::PDATA_W-1:0] pwdata,
  output logic [ffrc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import ffrc_pkg::*;

  centre_set_t  centres;
  logic         q_push, q_pop, q_full, q_empty;
  queue_entry_t push_entry, pop_entry;

  // midpoint registers
  ffrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .centres (centres)
  );

  // grading and weighted sums
  ffrc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .centres (centres),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // decoupling queue
  ffrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  // divider and output stage
  ffrc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (pop_entry),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
